// ===== hdl/txcon_pkg.sv =====
// Shared constants, command types and state encodings for the text console.
// No dependencies; every other file of the console imports this package.
`default_nettype none

package txcon_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int CELL_AW     = $clog2(CELL_COUNT);
    localparam int CELL_W      = 16;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int OP_W        = 2;
    localparam int INDEX_W     = 11;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [CHAR_W-1:0]  chr;
        logic [CELL_AW-1:0] index;
        logic               in_range;
    } t_cmd;

    typedef struct packed {
        logic q_full;
        logic init_busy;
    } t_front_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_RESULT
    } t_back_state;

endpackage

`default_nettype wire

// ===== hdl/txcon_front.sv =====
// Front end of the text console: input handshake and command classification.
// Depends on txcon_pkg; feeds commands into txcon_queue.
`default_nettype none

module txcon_front
    import txcon_pkg::*;
(
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [CHAR_W-1:0]  i_character,
    input  wire logic [INDEX_W-1:0] i_cell_index,
    input  wire t_front_ctl         i_ctl,
    output logic                    o_push,
    output t_cmd                    o_cmd
);

    always_comb begin
        o_in_stall = i_ctl.q_full || i_ctl.init_busy;
        o_push     = i_in_valid && !o_in_stall;
    end

    always_comb begin
        o_cmd.chr      = i_character;
        o_cmd.index    = CELL_AW'(i_cell_index);
        o_cmd.in_range = (32'(i_cell_index) < 32'(CELL_COUNT));
        case (i_operation)
            OP_PUT: begin
                o_cmd.kind = (i_character == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
            end
            OP_CLEAR: begin
                o_cmd.kind = CMD_CLEAR;
            end
            OP_READ: begin
                o_cmd.kind = CMD_READ;
            end
            default: begin
                o_cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/txcon_queue.sv =====
// Short command queue between the console front end and the execution back end.
// Depends on txcon_pkg for the command type and the queue depth.
`default_nettype none

module txcon_queue
    import txcon_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_full,
    output logic      o_empty
);

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW-1:0] n_wr_ptr;
    logic [QUEUE_AW-1:0] n_rd_ptr;
    logic [QUEUE_AW:0]   n_count;
    logic                do_push;
    logic                do_pop;

    always_comb begin
        o_full   = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
        o_empty  = (r_count == '0);
        o_head   = r_slot[r_rd_ptr];
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = do_push ? r_wr_ptr + QUEUE_AW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (QUEUE_AW + 1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/txcon_back.sv =====
// Back end of the text console: cell memory, cursor, scroll and fill sequencer,
// attribute register and the output result register. Depends on txcon_pkg.
`default_nettype none

module txcon_back
    import txcon_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [ATTR_W-1:0] i_cfg_data,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_q_empty,
    output logic                   o_pop,
    output logic                   o_init_busy,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [CELL_W-1:0]      o_cell_data,
    output logic [ROW_W-1:0]       o_cursor_row,
    output logic [COL_W-1:0]       o_cursor_col,
    output logic                   o_scrolled
);

    logic [CELL_W-1:0]  r_mem [CELL_COUNT];
    logic [CELL_W-1:0]  r_rd_data;

    t_back_state        r_state;
    t_back_state        n_state;
    logic [ATTR_W-1:0]  r_attr;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   r_col;
    logic [COL_W-1:0]   n_col;
    logic [CELL_AW-1:0] r_src;
    logic [CELL_AW-1:0] n_src;
    logic               r_copy_vld;
    logic               n_copy_vld;
    logic [CELL_AW-1:0] r_copy_dst;
    logic [CELL_AW-1:0] n_copy_dst;
    logic [CELL_AW-1:0] r_fill_addr;
    logic [CELL_AW-1:0] n_fill_addr;
    logic               r_fill_blank;
    logic               n_fill_blank;
    logic               r_init_busy;
    logic               n_init_busy;
    logic               r_res_read;
    logic               n_res_read;
    logic               r_res_in_range;
    logic               n_res_in_range;
    logic               r_res_scroll;
    logic               n_res_scroll;
    logic               r_out_valid;
    logic [CELL_W-1:0]  r_cell_data;
    logic [ROW_W-1:0]   r_out_row;
    logic [COL_W-1:0]   r_out_col;
    logic               r_out_scroll;

    logic               wr_en;
    logic [CELL_AW-1:0] wr_addr;
    logic [CELL_W-1:0]  wr_data;
    logic               rd_en;
    logic [CELL_AW-1:0] rd_addr;
    logic [CELL_AW-1:0] cur_addr;
    logic               row_last;
    logic               col_last;
    logic               src_last;
    logic               fill_last;
    logic               out_free;
    logic               load_out;
    logic [CELL_W-1:0]  blank_cell;

    always_comb begin
        cur_addr   = CELL_AW'(r_row) * CELL_AW'(COLUMNS) + CELL_AW'(r_col);
        row_last   = (r_row == ROW_W'(ROWS - 1));
        col_last   = (r_col == COL_W'(COLUMNS - 1));
        src_last   = (r_src == CELL_AW'(CELL_COUNT - 1));
        fill_last  = (r_fill_addr == CELL_AW'(CELL_COUNT - 1));
        out_free   = !r_out_valid || !i_out_stall;
        blank_cell = {r_attr, SPACE_CODE};
        o_pop      = (r_state == ST_IDLE) && !i_q_empty;
        load_out   = (r_state == ST_RESULT) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    case (i_cmd.kind)
                        CMD_PUT: begin
                            n_state = (col_last && row_last) ? ST_SCROLL : ST_RESULT;
                        end
                        CMD_NEWLINE: begin
                            n_state = row_last ? ST_SCROLL : ST_RESULT;
                        end
                        CMD_CLEAR: begin
                            n_state = ST_FILL;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                if (src_last) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (!r_copy_vld && fill_last) begin
                    n_state = r_init_busy ? ST_IDLE : ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_row          = r_row;
        n_col          = r_col;
        n_src          = r_src;
        n_copy_vld     = 1'b0;
        n_copy_dst     = r_copy_dst;
        n_fill_addr    = r_fill_addr;
        n_fill_blank   = r_fill_blank;
        n_init_busy    = r_init_busy;
        n_res_read     = r_res_read;
        n_res_in_range = r_res_in_range;
        n_res_scroll   = r_res_scroll;
        wr_en          = 1'b0;
        wr_addr        = cur_addr;
        wr_data        = {r_attr, i_cmd.chr};
        rd_en          = 1'b0;
        rd_addr        = i_cmd.index;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_res_read     = (i_cmd.kind == CMD_READ);
                    n_res_in_range = i_cmd.in_range;
                    n_res_scroll   = 1'b0;
                    n_src          = CELL_AW'(COLUMNS);
                    case (i_cmd.kind)
                        CMD_PUT: begin
                            wr_en = 1'b1;
                            if (col_last) begin
                                n_col = '0;
                                if (row_last) begin
                                    n_res_scroll = 1'b1;
                                end else begin
                                    n_row = r_row + ROW_W'(1);
                                end
                            end else begin
                                n_col = r_col + COL_W'(1);
                            end
                        end
                        CMD_NEWLINE: begin
                            n_col = '0;
                            if (row_last) begin
                                n_res_scroll = 1'b1;
                            end else begin
                                n_row = r_row + ROW_W'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            n_row        = '0;
                            n_col        = '0;
                            n_fill_addr  = '0;
                            n_fill_blank = 1'b1;
                        end
                        CMD_READ: begin
                            rd_en = i_cmd.in_range;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                rd_en      = 1'b1;
                rd_addr    = r_src;
                n_copy_vld = 1'b1;
                n_copy_dst = r_src - CELL_AW'(COLUMNS);
                n_src      = r_src + CELL_AW'(1);
                wr_en      = r_copy_vld;
                wr_addr    = r_copy_dst;
                wr_data    = r_rd_data;
                if (src_last) begin
                    n_fill_addr  = CELL_AW'(CELL_COUNT - COLUMNS);
                    n_fill_blank = 1'b1;
                end
            end
            ST_FILL: begin
                wr_en = 1'b1;
                if (r_copy_vld) begin
                    wr_addr = r_copy_dst;
                    wr_data = r_rd_data;
                end else begin
                    wr_addr     = r_fill_addr;
                    wr_data     = r_fill_blank ? blank_cell : '0;
                    n_fill_addr = r_fill_addr + CELL_AW'(1);
                    if (fill_last) begin
                        n_init_busy = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_FILL;
            r_attr       <= ATTR_RESET;
            r_row        <= '0;
            r_col        <= '0;
            r_copy_vld   <= 1'b0;
            r_fill_addr  <= '0;
            r_fill_blank <= 1'b0;
            r_init_busy  <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_col        <= n_col;
            r_copy_vld   <= n_copy_vld;
            r_fill_addr  <= n_fill_addr;
            r_fill_blank <= n_fill_blank;
            r_init_busy  <= n_init_busy;
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src          <= n_src;
        r_copy_dst     <= n_copy_dst;
        r_res_read     <= n_res_read;
        r_res_in_range <= n_res_in_range;
        r_res_scroll   <= n_res_scroll;
        if (load_out) begin
            r_cell_data  <= (r_res_read && r_res_in_range) ? r_rd_data : '0;
            r_out_row    <= r_row;
            r_out_col    <= r_col;
            r_out_scroll <= r_res_scroll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_init_busy  = r_init_busy;
    assign o_out_valid  = r_out_valid;
    assign o_cell_data  = r_cell_data;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_scrolled   = r_out_scroll;

endmodule

`default_nettype wire

// ===== hdl/text_console_scroll.sv =====
// Top level of the text console: front end, command queue and back end.
// Depends on txcon_pkg, txcon_front, txcon_queue and txcon_back.
//
// Usage: commands enter on the input channel (i_in_valid / o_in_stall) with
// an operation, a character and a cell index. Each accepted transaction gives
// exactly one result transaction on the output channel (o_out_valid /
// i_out_stall) carrying the read cell, the cursor after the command and the
// scroll flag. The attribute register is written on the configuration channel
// (i_cfg_valid / o_cfg_ready) and is always ready.
// A put, newline, read or unused operation passes from the queue through the
// back end's idle and result states to the result register; the back end
// takes a new command only from its idle state. A clear or a scroll writes
// every affected cell in turn, since the single write port of the cell memory
// touches one cell per cycle.
// A four-entry queue lets the front end keep accepting commands while the
// back end scrolls or while a result waits to be taken.
// After reset a clearing pass zeroes all 2000 cells of the cell memory; input
// stays stalled until it ends. While the receiver stalls, the result holds
// and the back end stops, and input stalls once the queue fills.
`default_nettype none

module text_console_scroll
    import txcon_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [CHAR_W-1:0]  i_character,
    input  wire logic [INDEX_W-1:0] i_cell_index,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [CELL_W-1:0]       o_cell_data,
    output logic [ROW_W-1:0]        o_cursor_row,
    output logic [COL_W-1:0]        o_cursor_col,
    output logic                    o_scrolled,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [ATTR_W-1:0]  i_cfg_data
);

    t_front_ctl front_ctl;
    t_cmd       push_cmd;
    t_cmd       head_cmd;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    logic       init_busy;

    assign front_ctl.q_full    = q_full;
    assign front_ctl.init_busy = init_busy;
    assign o_cfg_ready         = 1'b1;

    txcon_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_character  (i_character),
        .i_cell_index (i_cell_index),
        .i_ctl        (front_ctl),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    txcon_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    txcon_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (head_cmd),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .o_init_busy  (init_busy),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_data  (o_cell_data),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_scrolled   (o_scrolled)
    );

endmodule

`default_nettype wire

// ===== hdl/txcon_checker.sv =====
// Port-level checks for the text console and the bind that attaches them.
// Depends on txcon_pkg and on the text_console_scroll top level.
`default_nettype none

module txcon_checker
    import txcon_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [CELL_W-1:0] o_cell_data,
    input wire logic [ROW_W-1:0]  o_cursor_row,
    input wire logic [COL_W-1:0]  o_cursor_col,
    input wire logic              o_scrolled
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cell_data)
            && $stable(o_cursor_row) && $stable(o_cursor_col))
        else $error("Stalled result changed or dropped.");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cursor_row <= ROW_W'(ROWS - 1))
            && (o_cursor_col <= COL_W'(COLUMNS - 1)))
        else $error("Cursor outside the grid.");

    a_scroll_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |-> (o_cursor_row == ROW_W'(ROWS - 1))
            && (o_cell_data == '0))
        else $error("Scroll result without cursor on the last row.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("Input not stalled during the clearing pass.");

endmodule

bind text_console_scroll txcon_checker u_txcon_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_cell_data  (o_cell_data),
    .o_cursor_row (o_cursor_row),
    .o_cursor_col (o_cursor_col),
    .o_scrolled   (o_scrolled)
);

`default_nettype wire

// ===== dv/tb_text_console_scroll.sv =====
// Self-checking testbench for the text console: a stimulus table, then phases of
// random put, newline, clear and read transactions checked against a predictor.
// Depends on txcon_pkg and text_console_scroll.
`default_nettype none

module tb_text_console_scroll
    import txcon_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CELL_W-1:0] data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              scrolled;
    } t_console_out;

    typedef struct packed {
        t_op                op;
        logic [CHAR_W-1:0]  chr;
        logic [INDEX_W-1:0] idx;
        logic               known;
        t_console_out       want;
    } t_stim_row;

    localparam int DIRECTED_COUNT = 21;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 175;

    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{OP_READ,  8'h00, 11'd0,    1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
        '{OP_READ,  8'h00, 11'd1999, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
        '{OP_READ,  8'hFF, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
        '{OP_NONE,  8'hFF, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
        '{OP_PUT,   8'h41, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd1, 1'b0}},
        '{OP_PUT,   8'hFF, 11'd0,    1'b1, '{16'h0000, 5'd0, 7'd2, 1'b0}},
        '{OP_PUT,   8'h00, 11'd1,    1'b1, '{16'h0000, 5'd0, 7'd3, 1'b0}},
        '{OP_READ,  8'h0A, 11'd0,    1'b1, '{16'h0741, 5'd0, 7'd3, 1'b0}},
        '{OP_READ,  8'h00, 11'd1,    1'b1, '{16'h07FF, 5'd0, 7'd3, 1'b0}},
        '{OP_READ,  8'h00, 11'd2,    1'b1, '{16'h0700, 5'd0, 7'd3, 1'b0}},
        '{OP_READ,  8'h00, 11'd3,    1'b1, '{16'h0000, 5'd0, 7'd3, 1'b0}},
        '{OP_PUT,   8'h0A, 11'd0,    1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0}},
        '{OP_PUT,   8'h80, 11'd0,    1'b1, '{16'h0000, 5'd1, 7'd1, 1'b0}},
        '{OP_READ,  8'h00, 11'd80,   1'b1, '{16'h0780, 5'd1, 7'd1, 1'b0}},
        '{OP_NONE,  8'h0A, 11'd0,    1'b1, '{16'h0000, 5'd1, 7'd1, 1'b0}},
        '{OP_READ,  8'h00, 11'd2000, 1'b1, '{16'h0000, 5'd1, 7'd1, 1'b0}},
        '{OP_CLEAR, 8'h41, 11'd5,    1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
        '{OP_READ,  8'h00, 11'd0,    1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
        '{OP_READ,  8'h00, 11'd1999, 1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
        '{OP_PUT,   8'h7F, 11'd1024, 1'b0, '0},
        '{OP_READ,  8'h55, 11'd0,    1'b0, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [OP_W-1:0]    i_operation;
    logic [CHAR_W-1:0]  i_character;
    logic [INDEX_W-1:0] i_cell_index;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [CELL_W-1:0]  o_cell_data;
    logic [ROW_W-1:0]   o_cursor_row;
    logic [COL_W-1:0]   o_cursor_col;
    logic               o_scrolled;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [ATTR_W-1:0]  i_cfg_data;

    logic [CELL_W-1:0]  shadow_cells [CELL_COUNT];
    logic [ROW_W-1:0]   shadow_row;
    logic [COL_W-1:0]   shadow_col;
    logic [ATTR_W-1:0]  shadow_attr;

    t_console_out pending_results [$];
    int           mismatch_count;
    bit           calm;
    bit           long_hold_req;

    text_console_scroll DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_character  (i_character),
        .i_cell_index (i_cell_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_data  (o_cell_data),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_scrolled   (o_scrolled),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_console_out console_apply(input t_op op,
                                                   input logic [CHAR_W-1:0] chr,
                                                   input logic [INDEX_W-1:0] idx);
        t_console_out r;
        int unsigned  pos;
        r = '0;
        case (op)
            OP_PUT: begin
                if (chr == NEWLINE_CODE) begin
                    shadow_row = shadow_row + ROW_W'(1);
                    shadow_col = '0;
                end else begin
                    pos = shadow_row * COLUMNS + shadow_col;
                    if (pos < CELL_COUNT) begin
                        shadow_cells[pos] = {shadow_attr, chr};
                    end
                    shadow_col = shadow_col + COL_W'(1);
                    if (shadow_col >= COLUMNS) begin
                        shadow_col = '0;
                        shadow_row = shadow_row + ROW_W'(1);
                    end
                end
                if (shadow_row >= ROWS) begin
                    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
                        shadow_cells[i] = shadow_cells[i + COLUMNS];
                    end
                    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
                        shadow_cells[i] = {shadow_attr, SPACE_CODE};
                    end
                    shadow_row = ROW_W'(ROWS - 1);
                    r.scrolled = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++) begin
                    shadow_cells[i] = {shadow_attr, SPACE_CODE};
                end
                shadow_row = '0;
                shadow_col = '0;
            end
            OP_READ: begin
                if (idx < CELL_COUNT) begin
                    r.data = shadow_cells[idx];
                end
            end
            default: begin
            end
        endcase
        r.row = shadow_row;
        r.col = shadow_col;
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] text_byte();
        logic [CHAR_W-1:0] b;
        b = CHAR_W'($urandom_range(0, 255));
        if (b == NEWLINE_CODE) begin
            b = SPACE_CODE;
        end
        return b;
    endfunction

    task automatic send_command(input t_op op, input logic [CHAR_W-1:0] chr,
                                input logic [INDEX_W-1:0] idx, input logic known,
                                input t_console_out want);
        t_console_out predicted;
        int           gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_character  <= chr;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        predicted = console_apply(op, chr, idx);
        pending_results.push_back(known ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic send_random(input t_op op, input logic [CHAR_W-1:0] chr);
        send_command(op, chr, INDEX_W'($urandom_range(0, 2047)), 1'b0, '0);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_attr = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = 299;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 8);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_console_out want;
        if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: cell_data %h", o_cell_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_cell_data !== want.data) begin
                    $error("cell_data: expected %h, actual %h", want.data, o_cell_data);
                    mismatch_count++;
                end
                if (o_cursor_row !== want.row) begin
                    $error("cursor_row: expected %0d, actual %0d", want.row, o_cursor_row);
                    mismatch_count++;
                end
                if (o_cursor_col !== want.col) begin
                    $error("cursor_col: expected %0d, actual %0d", want.col, o_cursor_col);
                    mismatch_count++;
                end
                if (o_scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0d, actual %0d", want.scrolled, o_scrolled);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_op                op;
        logic [CHAR_W-1:0]  chr;
        logic [INDEX_W-1:0] idx;
        int                 pick;
        mismatch_count = 0;
        calm           = 1'b0;
        long_hold_req  = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = OP_NONE;
        i_character    = '0;
        i_cell_index   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        for (int i = 0; i < CELL_COUNT; i++) begin
            shadow_cells[i] = '0;
        end
        shadow_row  = '0;
        shadow_col  = '0;
        shadow_attr = ATTR_RESET;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_command(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].chr, DIRECTED_ROWS[i].idx,
                         DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_results_drained();
            calm = (p == 1) || (p >= PHASE_COUNT - 2);
            if (p == 0) begin
                write_attribute(8'hFF);
            end else if (p == 1) begin
                write_attribute(8'h00);
            end else begin
                write_attribute(ATTR_W'($urandom_range(0, 255)));
            end
            if (p == 2) begin
                long_hold_req = 1'b1;
            end

            // Walk the cursor down to the last row, then scroll once by column
            // wrap and once by newline.
            if (p % 2 == 0) begin
                send_random(OP_CLEAR, text_byte());
                for (int r = 0; r < ROWS - 1; r++) begin
                    repeat ($urandom_range(0, 3)) send_random(OP_PUT, text_byte());
                    send_random(OP_PUT, NEWLINE_CODE);
                end
                repeat (COLUMNS) send_random(OP_PUT, text_byte());
                send_random(OP_PUT, NEWLINE_CODE);
                repeat (8) begin
                    send_command(OP_READ, text_byte(),
                                 INDEX_W'($urandom_range(CELL_COUNT - 2 * COLUMNS,
                                                         CELL_COUNT - 1)), 1'b0, '0);
                end
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == PHASE_ITEMS / 2) begin
                    wait_results_drained();
                end
                pick = $urandom_range(0, 199);
                chr  = CHAR_W'($urandom_range(0, 255));
                idx  = INDEX_W'($urandom_range(0, 2047));
                if (pick < 100) begin
                    op = OP_PUT;
                end else if (pick < 108) begin
                    op  = OP_PUT;
                    chr = NEWLINE_CODE;
                end else if (pick < 180) begin
                    op   = OP_READ;
                    pick = $urandom_range(0, 9);
                    if (pick < 3) begin
                        idx = INDEX_W'($urandom_range(CELL_COUNT - 2 * COLUMNS,
                                                      CELL_COUNT - 1));
                    end else if (pick < 9) begin
                        idx = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
                    end else begin
                        idx = INDEX_W'($urandom_range(CELL_COUNT, 2047));
                    end
                end else if (pick < 190) begin
                    op = OP_NONE;
                end else if (pick < 191) begin
                    op = OP_CLEAR;
                end else begin
                    op = OP_PUT;
                end
                send_command(op, chr, idx, 1'b0, '0);
            end
        end

        wait_results_drained();
        repeat (16) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/txcon_pkg.sv
hdl/txcon_front.sv
hdl/txcon_queue.sv
hdl/txcon_back.sv
hdl/text_console_scroll.sv
hdl/txcon_checker.sv
dv/tb_text_console_scroll.sv
